### sv/mtsr_pkg.sv
// Shared types, register indexes and constants of the multi-tap switch relay.
package mtsr_pkg;

  localparam int unsigned TimeBitsDefault = 16;
  localparam int unsigned CfgBits         = 16;
  localparam int unsigned TapBits         = 4;
  localparam int unsigned AddrBits        = 4;
  localparam int unsigned DataBits        = 32;

  localparam logic [CfgBits-1:0] DebounceReset = 16'd50;
  localparam logic [CfgBits-1:0] TimeoutReset  = 16'd300;
  localparam logic               IdleLevelReset = 1'b0;

  localparam logic [TapBits-1:0] TapMax      = 4'd15;
  localparam logic [TapBits-1:0] TapsSpecial = 4'd2;
  localparam logic [TapBits-1:0] TapsRestart = 4'd6;

  typedef enum logic [1:0] {
    RegDebounce  = 2'd0,
    RegTimeout   = 2'd1,
    RegIdleLevel = 2'd2,
    RegUnused    = 2'd3
  } mtsr_reg_e;

  typedef enum logic {
    OpTick    = 1'b0,
    OpCommand = 1'b1
  } mtsr_op_e;

  typedef struct packed {
    logic [CfgBits-1:0] debounce_ticks;
    logic [CfgBits-1:0] tap_timeout_ticks;
    logic               idle_level;
    logic               idle_level_wr;
  } mtsr_cfg_t;

  typedef struct packed {
    logic relay_on;
    logic status_event;
    logic special_event;
    logic restart_request;
  } mtsr_res_t;

endpackage

### sv/mtsr_in_if.sv
// Input channel interface carrying tick and command items.
interface mtsr_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic switch_level;
  logic relay_target;

  modport source (output valid, output operation, output switch_level,
                  output relay_target, input ready);
  modport sink (input valid, input operation, input switch_level,
                input relay_target, output ready);
endinterface

### sv/mtsr_out_if.sv
// Output channel interface carrying one result per item.
interface mtsr_out_if;
  logic valid;
  logic ready;
  logic relay_on;
  logic status_event;
  logic special_event;
  logic restart_request;

  modport source (output valid, output relay_on, output status_event,
                  output special_event, output restart_request, input ready);
  modport sink (input valid, input relay_on, input status_event,
                input special_event, input restart_request, output ready);
endinterface

### sv/multi_tap_switch_relay_core.sv
// Top level of the multi-tap switch relay: config port, core state and result register.
// Timing: a result is registered and valid in the cycle after its input transfer.
// Throughput: one item per cycle unless the output stalls; the output register lets
// a new input transfer take place in the same cycle as the waiting result is taken.
// Reset: rst_ni clears all state but the result register asynchronously; the
// other registers take reset values and the stable level takes the reset idle level.
module multi_tap_switch_relay_core #(
  parameter int unsigned TIME_BITS = mtsr_pkg::TimeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtsr_pkg::AddrBits-1:0] paddr,
  input  logic [mtsr_pkg::DataBits-1:0] pwdata,
  output logic [mtsr_pkg::DataBits-1:0] prdata,
  output logic                          pready,
  mtsr_in_if.sink                       in_i,
  mtsr_out_if.source                    out_o
);
  import mtsr_pkg::*;

  mtsr_cfg_t cfg;
  mtsr_res_t res;
  mtsr_res_t res_q;
  logic      out_valid_q;
  logic      accept;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  mtsr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mtsr_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .operation_i    (in_i.operation),
    .switch_level_i (in_i.switch_level),
    .relay_target_i (in_i.relay_target),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.relay_on        = res_q.relay_on;
  assign out_o.status_event    = res_q.status_event;
  assign out_o.special_event   = res_q.special_event;
  assign out_o.restart_request = res_q.restart_request;

endmodule

### sv/mtsr_cfg.sv
// APB-style configuration register file of the multi-tap switch relay.
module mtsr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtsr_pkg::AddrBits-1:0] paddr,
  input  logic [mtsr_pkg::DataBits-1:0] pwdata,
  output logic [mtsr_pkg::DataBits-1:0] prdata,
  output logic                          pready,
  output mtsr_pkg::mtsr_cfg_t           cfg_o
);
  import mtsr_pkg::*;

  logic [CfgBits-1:0] debounce_q, debounce_d;
  logic [CfgBits-1:0] timeout_q, timeout_d;
  logic               idle_q, idle_d;
  logic               wr_en;
  logic               idle_wr;
  mtsr_reg_e          reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = mtsr_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_comb begin
    debounce_d = debounce_q;
    timeout_d  = timeout_q;
    idle_d     = idle_q;
    idle_wr    = 1'b0;
    if (wr_en) begin
      unique case (reg_sel)
        RegDebounce: debounce_d = pwdata[CfgBits-1:0];
        RegTimeout:  timeout_d  = pwdata[CfgBits-1:0];
        RegIdleLevel: begin
          idle_d  = pwdata[0];
          idle_wr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegDebounce:  prdata = DataBits'(debounce_q);
      RegTimeout:   prdata = DataBits'(timeout_q);
      RegIdleLevel: prdata = DataBits'(idle_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
      timeout_q  <= TimeoutReset;
      idle_q     <= IdleLevelReset;
    end else begin
      debounce_q <= debounce_d;
      timeout_q  <= timeout_d;
      idle_q     <= idle_d;
    end
  end

  assign cfg_o.debounce_ticks    = debounce_q;
  assign cfg_o.tap_timeout_ticks = timeout_q;
  assign cfg_o.idle_level        = idle_d;
  assign cfg_o.idle_level_wr     = idle_wr;

endmodule

### sv/mtsr_core.sv
// Debounce vote, tap counter, idle timer and tap decoder with their state.
module mtsr_core #(
  parameter int unsigned TIME_BITS = mtsr_pkg::TimeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                operation_i,
  input  logic                switch_level_i,
  input  logic                relay_target_i,
  input  mtsr_pkg::mtsr_cfg_t cfg_i,
  output mtsr_pkg::mtsr_res_t res_o
);
  import mtsr_pkg::*;

  localparam int unsigned CmpBits = (TIME_BITS > CfgBits) ? TIME_BITS : CfgBits;
  localparam logic [TIME_BITS-1:0] TimerMax = '1;

  logic                 stable_q, stable_d;
  logic                 relay_q, relay_d;
  logic [TapBits-1:0]   tap_q, tap_d;
  logic [TIME_BITS-1:0] timer_q, timer_d;
  logic                 voting_q, voting_d;
  logic [CfgBits-1:0]   window_q, window_d;
  logic [CfgBits-1:0]   vfor_q, vfor_d;
  logic [CfgBits-1:0]   vagainst_q, vagainst_d;
  logic                 differs;

  assign differs = switch_level_i ^ stable_q;

  always_comb begin
    stable_d   = stable_q;
    relay_d    = relay_q;
    tap_d      = tap_q;
    timer_d    = timer_q;
    voting_d   = voting_q;
    window_d   = window_q;
    vfor_d     = vfor_q;
    vagainst_d = vagainst_q;
    res_o      = '0;

    if (mtsr_op_e'(operation_i) == OpCommand) begin
      relay_d            = relay_target_i;
      res_o.status_event = 1'b1;
    end else begin
      if (tap_q != '0) begin
        if (timer_q != TimerMax) begin
          timer_d = timer_q + TIME_BITS'(1);
        end
      end else begin
        timer_d = '0;
      end

      if (voting_q) begin
        if (differs) begin
          vfor_d = vfor_q + CfgBits'(1);
        end else begin
          vagainst_d = vagainst_q + CfgBits'(1);
        end
        window_d = window_q - CfgBits'(1);
        if (window_d == '0) begin
          if (vfor_d > vagainst_d) begin
            stable_d = ~stable_q;
            if (tap_q != TapMax) begin
              tap_d = tap_q + TapBits'(1);
            end
            timer_d = '0;
          end
          voting_d   = 1'b0;
          window_d   = '0;
          vfor_d     = '0;
          vagainst_d = '0;
        end
      end else if (differs && (cfg_i.debounce_ticks != '0)) begin
        voting_d   = 1'b1;
        window_d   = cfg_i.debounce_ticks;
        vfor_d     = '0;
        vagainst_d = '0;
      end

      if (!voting_d && (tap_d != '0) &&
          (CmpBits'(timer_d) > CmpBits'(cfg_i.tap_timeout_ticks))) begin
        if (tap_d[0]) begin
          relay_d            = ~relay_d;
          res_o.status_event = 1'b1;
        end else if (tap_d == TapsSpecial) begin
          res_o.special_event = 1'b1;
        end else if (tap_d == TapsRestart) begin
          relay_d               = 1'b0;
          res_o.restart_request = 1'b1;
        end
        tap_d   = '0;
        timer_d = '0;
      end
    end
    res_o.relay_on = relay_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= IdleLevelReset;
      relay_q    <= 1'b0;
      tap_q      <= '0;
      timer_q    <= '0;
      voting_q   <= 1'b0;
      window_q   <= '0;
      vfor_q     <= '0;
      vagainst_q <= '0;
    end else if (cfg_i.idle_level_wr) begin
      stable_q   <= cfg_i.idle_level;
      voting_q   <= 1'b0;
      window_q   <= '0;
      vfor_q     <= '0;
      vagainst_q <= '0;
    end else if (accept_i) begin
      stable_q   <= stable_d;
      relay_q    <= relay_d;
      tap_q      <= tap_d;
      timer_q    <= timer_d;
      voting_q   <= voting_d;
      window_q   <= window_d;
      vfor_q     <= vfor_d;
      vagainst_q <= vagainst_d;
    end
  end

endmodule
